@@ rtl/core/double_to_minifloat_encode_core_assert.svh @@
// Assertion macros used by the conversion core top level
`ifndef DOUBLE_TO_MINIFLOAT_ENCODE_CORE_ASSERT_SVH
`define DOUBLE_TO_MINIFLOAT_ENCODE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define D2M_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define D2M_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define D2M_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define D2M_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/d2m_pkg.sv @@
// Types and constants of the binary64 to narrow float converter
package d2m_pkg;
    localparam logic [1:0] RM_AWAY  = 2'd0;
    localparam logic [1:0] RM_TRUNC = 2'd1;
    localparam logic [1:0] RM_EVEN  = 2'd2;

    localparam logic [1:0] REG_EXP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAC_WIDTH = 2'd1;
    localparam logic [1:0] REG_ROUND_MODE = 2'd2;

    // class of an operand, decided in the first stage
    localparam logic [1:0] CLS_NUM  = 2'd0;
    localparam logic [1:0] CLS_ZERO = 2'd1;
    localparam logic [1:0] CLS_INF  = 2'd2;
    localparam logic [1:0] CLS_NAN  = 2'd3;

    // per-word control that travels with the data
    typedef struct packed {
        logic       sign;
        logic [1:0] cls;
        logic [3:0] ew;
        logic [5:0] fw;
        logic [1:0] rm;
    } d2m_ctl_t;
endpackage

@@ rtl/core/d2m_norm.sv @@
// Stage 1 and 2: classify the operand and normalize its significand
module d2m_norm
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  logic [63:0]         src,
    input  d2m_pkg::d2m_ctl_t   in_ctl,
    output logic                out_vld,
    output d2m_pkg::d2m_ctl_t   out_ctl,
    output logic [52:0]         sig,
    output logic signed [12:0]  exp_unb
);
    // stage 1 registers: raw fields plus leading zero count
    logic              s1_vld_reg;
    d2m_pkg::d2m_ctl_t s1_ctl_reg;
    logic [51:0]       s1_man_reg;
    logic              s1_sub_reg;
    logic [10:0]       s1_exp_reg;
    logic [5:0]        s1_lz_reg;
    logic [5:0]        lz_next;
    d2m_pkg::d2m_ctl_t ctl_next;
    logic              out_vld_reg;
    d2m_pkg::d2m_ctl_t out_ctl_reg;
    logic [52:0]       sig_reg;
    logic signed [12:0] exp_reg;

    always_comb
    begin
        lz_next = 6'd51;
        for (int i = 0; i <= 51; i++)
        begin
            if (src[i]) lz_next = 6'(51 - i);
        end
        ctl_next = in_ctl;
        ctl_next.sign = src[63];
        if (src[62:52] == 11'h7FF)
            ctl_next.cls = (src[51:0] != '0) ? d2m_pkg::CLS_NAN : d2m_pkg::CLS_INF;
        else if (src[62:0] == '0)
            ctl_next.cls = d2m_pkg::CLS_ZERO;
        else
            ctl_next.cls = d2m_pkg::CLS_NUM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= in_vld;
            out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ctl_reg <= ctl_next;
        s1_man_reg <= src[51:0];
        s1_sub_reg <= (src[62:52] == '0);
        s1_exp_reg <= src[62:52];
        s1_lz_reg  <= lz_next;
        out_ctl_reg <= s1_ctl_reg;
        if (s1_sub_reg)
        begin
            sig_reg <= {1'b0, s1_man_reg} << (s1_lz_reg + 6'd1);
            exp_reg <= -13'sd1023 - $signed({7'd0, s1_lz_reg});
        end
        else
        begin
            sig_reg <= {1'b1, s1_man_reg};
            exp_reg <= $signed({2'b00, s1_exp_reg}) - 13'sd1023;
        end
    end

    assign out_vld = out_vld_reg;
    assign out_ctl = out_ctl_reg;
    assign sig     = sig_reg;
    assign exp_unb = exp_reg;
endmodule

@@ rtl/core/d2m_round.sv @@
// Stages 3 to 5: align, round and pack the narrow float
module d2m_round
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  d2m_pkg::d2m_ctl_t   in_ctl,
    input  logic [52:0]         sig,
    input  logic signed [12:0]  exp_unb,
    output logic                out_vld,
    output logic [63:0]         packed_out
);
    // stage 3: biased exponent and shift amount
    logic              s3_vld_reg;
    d2m_pkg::d2m_ctl_t s3_ctl_reg;
    logic [52:0]       s3_sig_reg;
    logic signed [13:0] s3_ef_reg;
    logic [12:0]       s3_shift_reg;
    logic              s3_ovf_reg;
    // stage 4: kept bits and round flags
    logic              s4_vld_reg;
    d2m_pkg::d2m_ctl_t s4_ctl_reg;
    logic [52:0]       s4_kept_reg;
    logic              s4_rb_reg;
    logic              s4_sb_reg;
    logic signed [13:0] s4_ef_reg;
    logic              s4_ovf_reg;
    logic              out_vld_reg;
    logic [63:0]       pk_reg;

    logic signed [13:0] ef_next;
    logic signed [13:0] sh_next;
    logic [11:0]        expmax3;
    logic [5:0]         sh6;
    logic [52:0]        kept_next;
    logic               rb_next;
    logic               sb_next;
    logic [63:0]        expmax5;
    logic [63:0]        inf_mag;
    logic [63:0]        mag;
    logic               up;
    logic [63:0]        pk_next;

    always_comb
    begin
        expmax3 = (12'd1 << in_ctl.ew) - 12'd1;
        ef_next = 14'(exp_unb) + 14'((14'sd1 <<< (in_ctl.ew - 4'd1)) - 14'sd1);
        sh_next = 14'sd52 - $signed({8'd0, in_ctl.fw});
        if (ef_next <= 0) sh_next = sh_next + 14'sd1 - ef_next;
    end

    always_comb
    begin
        sh6 = s3_shift_reg[5:0];
        if (s3_shift_reg == 13'd0)
        begin
            kept_next = s3_sig_reg;
            rb_next   = 1'b0;
            sb_next   = 1'b0;
        end
        else if (s3_shift_reg <= 13'd53)
        begin
            kept_next = s3_sig_reg >> sh6;
            rb_next   = s3_sig_reg[sh6 - 6'd1];
            sb_next   = (s3_sig_reg & ((53'd1 << (sh6 - 6'd1)) - 53'd1)) != '0;
        end
        else
        begin
            kept_next = '0;
            rb_next   = 1'b0;
            sb_next   = 1'b1;
        end
    end

    always_comb
    begin
        expmax5 = (64'd1 << s4_ctl_reg.ew) - 64'd1;
        inf_mag = expmax5 << s4_ctl_reg.fw;
        if (s4_ef_reg >= 14'sd1)
            mag = (64'(s4_ef_reg - 14'sd1) << s4_ctl_reg.fw) + 64'(s4_kept_reg);
        else
            mag = 64'(s4_kept_reg);
        unique case (s4_ctl_reg.rm)
            d2m_pkg::RM_AWAY: up = s4_rb_reg | s4_sb_reg;
            d2m_pkg::RM_EVEN: up = s4_rb_reg & (s4_sb_reg | s4_kept_reg[0]);
            default:          up = 1'b0;
        endcase
        if (up) mag = mag + 64'd1;
        if (s4_ovf_reg || mag >= inf_mag) mag = inf_mag;
        unique case (s4_ctl_reg.cls)
            d2m_pkg::CLS_ZERO: pk_next = '0;
            d2m_pkg::CLS_INF:
                pk_next = inf_mag | (64'(s4_ctl_reg.sign) << (s4_ctl_reg.ew + s4_ctl_reg.fw));
            d2m_pkg::CLS_NAN:
                pk_next = inf_mag | (64'd1 << (s4_ctl_reg.fw - 6'd1))
                        | (64'(s4_ctl_reg.sign) << (s4_ctl_reg.ew + s4_ctl_reg.fw));
            default:
                pk_next = mag | (64'(s4_ctl_reg.sign) << (s4_ctl_reg.ew + s4_ctl_reg.fw));
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg  <= in_vld;
            s4_vld_reg  <= s3_vld_reg;
            out_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_ctl_reg   <= in_ctl;
        s3_sig_reg   <= sig;
        s3_ef_reg    <= ef_next;
        s3_shift_reg <= 13'(sh_next);
        s3_ovf_reg   <= ef_next >= $signed({2'b00, expmax3});
        s4_ctl_reg   <= s3_ctl_reg;
        s4_kept_reg  <= kept_next;
        s4_rb_reg    <= rb_next;
        s4_sb_reg    <= sb_next;
        s4_ef_reg    <= s3_ef_reg;
        s4_ovf_reg   <= s3_ovf_reg;
        pk_reg       <= pk_next;
    end

    assign out_vld    = out_vld_reg;
    assign packed_out = pk_reg;
endmodule

@@ rtl/core/double_to_minifloat_encode_core.sv @@
// Top level of the binary64 to narrow float conversion pipeline
// Throughput: one word per cycle; busy stays low, the five register stages
// of the classify, normalize, align, round and pack pipeline each take a word.
// Reset: rst_n clears all valid bits at once and loads the format
// registers with 8 exponent bits, 23 fraction bits and nearest even.
`include "double_to_minifloat_encode_core_assert.svh"
module double_to_minifloat_encode_core
#(
    parameter int MAX_EXP_WIDTH  = 11,
    parameter int MAX_FRAC_WIDTH = 52
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] source_bits,
    output logic        done,
    output logic [63:0] packed_float,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    logic [3:0]        ew_reg;
    logic [5:0]        fw_reg;
    logic [1:0]        rm_reg;
    logic [3:0]        ew_clamp;
    logic [5:0]        fw_clamp;
    logic              go;
    d2m_pkg::d2m_ctl_t in_ctl;
    logic              n_vld;
    d2m_pkg::d2m_ctl_t n_ctl;
    logic [52:0]       n_sig;
    logic signed [12:0] n_exp;

    // accept a word every cycle; the pipeline never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign go        = start & ~busy;

    // clamp the format to the supported range before it enters the pipe
    always_comb
    begin
        if (ew_reg < 4'd2) ew_clamp = 4'd2;
        else if (ew_reg > 4'(MAX_EXP_WIDTH)) ew_clamp = 4'(MAX_EXP_WIDTH);
        else ew_clamp = ew_reg;
        if (fw_reg < 6'd1) fw_clamp = 6'd1;
        else if (fw_reg > 6'(MAX_FRAC_WIDTH)) fw_clamp = 6'(MAX_FRAC_WIDTH);
        else fw_clamp = fw_reg;
        in_ctl      = '0;
        in_ctl.ew   = ew_clamp;
        in_ctl.fw   = fw_clamp;
        in_ctl.rm   = rm_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ew_reg <= 4'd8;
            fw_reg <= 6'd23;
            rm_reg <= d2m_pkg::RM_EVEN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                d2m_pkg::REG_EXP_WIDTH:  ew_reg <= cfg_data[3:0];
                d2m_pkg::REG_FRAC_WIDTH: fw_reg <= cfg_data;
                d2m_pkg::REG_ROUND_MODE: rm_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    d2m_norm u_norm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (go),
        .src     (source_bits),
        .in_ctl  (in_ctl),
        .out_vld (n_vld),
        .out_ctl (n_ctl),
        .sig     (n_sig),
        .exp_unb (n_exp)
    );

    d2m_round u_round
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_vld     (n_vld),
        .in_ctl     (n_ctl),
        .sig        (n_sig),
        .exp_unb    (n_exp),
        .out_vld    (done),
        .packed_out (packed_float)
    );

    `D2M_ASSERT_IMPL(a_norm_msb, clk, rst_n, n_vld && n_ctl.cls == d2m_pkg::CLS_NUM, n_sig[52])
    `D2M_ASSERT_NEXT(a_no_busy, clk, rst_n, 1'b1, !busy)
    `D2M_ASSERT_IMPL(a_zero_out, clk, rst_n, done && $past(n_ctl.cls, 3) == d2m_pkg::CLS_ZERO && $past(n_vld, 3), packed_float == '0)
endmodule
